// ===== rtl/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants for the SD card SPI-mode init sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE, PH_DESEL, PH_SEL, PH_READY, PH_FRAME,
        PH_RESP, PH_R7, PH_OCR, PH_FINAL, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_CMD0, ST_CMD8, ST_V2_INIT, ST_CMD58, ST_V2_CMD16,
        ST_V1_PROBE, ST_V1_INIT, ST_V1_CMD16
    } t_stage;

    localparam logic [3:0] KIND_MMC   = 4'h1;
    localparam logic [3:0] KIND_SD1   = 4'h2;
    localparam logic [3:0] KIND_SD2   = 4'h4;
    localparam logic [3:0] KIND_BLOCK = 4'h8;

    localparam logic [7:0] CMD_GO_IDLE = 8'd0;
    localparam logic [7:0] CMD_SEND_OP = 8'd1;
    localparam logic [7:0] CMD_IF_COND = 8'd8;
    localparam logic [7:0] CMD_BLKLEN  = 8'd16;
    localparam logic [7:0] CMD_APP     = 8'd55;
    localparam logic [7:0] CMD_OCR     = 8'd58;
    localparam logic [7:0] ACMD41      = 8'hA9;

    localparam logic [1:0] REG_READY_WAIT = 2'd0;
    localparam logic [1:0] REG_RETRY      = 2'd1;
    localparam logic [1:0] REG_POLL       = 2'd2;
    localparam logic [1:0] REG_WAKE       = 2'd3;

endpackage

// ===== rtl/sd_spi_card_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_card_init_sequencer
// Byte-level SPI-mode SD/MMC card initialization sequencer.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | i_valid / o_stall    | opcode, drive_number, received_byte
// out     | output    | o_valid / i_stall    | send_byte .. not_initialized
// cfg     | input     | APB psel/penable     | four limit registers
//
// One item per cycle while not stalled: next state and result word come from
// one level of logic after the accepted word and land in the output register.
// A new word is taken while the output register is empty or being drained.
// Reset (synchronous, active low) returns to idle with reset limits.
// ----------------------------------------------------------------------------
module sd_spi_card_init_sequencer
    import sdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_drive_number,
    input  logic [7:0]  i_received_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_send_byte,
    output logic        o_exchange_request,
    output logic        o_chip_select_high,
    output logic        o_fast_clock,
    output logic        o_sequence_done,
    output logic [3:0]  o_card_kind,
    output logic        o_not_initialized,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_ready_lim, r_retry_lim;
    logic [7:0]  r_poll_lim, r_wake_lim;

    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [15:0] r_wait, n_wait, r_retry, n_retry;
    logic [7:0]  r_poll, n_poll, r_cmd, n_cmd;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_arg, n_arg;
    logic [7:0]  r_rep0, n_rep0, r_rep2, n_rep2;
    logic [3:0]  r_kind, n_kind, r_pend, n_pend;
    logic        r_notinit, n_notinit, r_pfx, n_pfx, r_fast, n_fast;

    logic        tx_req, tx_cs;
    logic [7:0]  tx_byte;
    logic        rejected;

    logic        accept;
    logic        cfg_wr;

    assign o_stall = o_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_READY_WAIT: prdata = {16'd0, r_ready_lim};
            REG_RETRY:      prdata = {16'd0, r_retry_lim};
            REG_POLL:       prdata = {24'd0, r_poll_lim};
            default:        prdata = {24'd0, r_wake_lim};
        endcase
    end

    // frame byte for a given position, command and prefix
    function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [7:0] cmd,
                                              input logic [31:0] arg, input logic pfx);
        logic [7:0]  c;
        logic [31:0] a;
        c = pfx ? CMD_APP : cmd;
        a = pfx ? 32'd0 : arg;
        unique case (pos)
            3'd0: frame_byte = (c & 8'h7F) | 8'h40;
            3'd1: frame_byte = a[31:24];
            3'd2: frame_byte = a[23:16];
            3'd3: frame_byte = a[15:8];
            3'd4: frame_byte = a[7:0];
            default: frame_byte = (c == CMD_GO_IDLE) ? 8'h95 :
                                  (c == CMD_IF_COND) ? 8'h87 : 8'h01;
        endcase
    endfunction

    always_comb begin
        logic [7:0]  r;
        logic        do_cmd;      // command finished with response resp
        logic [7:0]  resp;
        logic        do_issue;
        logic [7:0]  icmd;
        logic [31:0] iarg;
        logic        do_finish;
        logic [3:0]  fkind;
        logic        do_retry;
        logic [15:0] rc;
        logic [7:0]  pc;
        logic [2:0]  np;

        r = i_received_byte;
        do_cmd = 1'b0; resp = 8'hFF;
        do_issue = 1'b0; icmd = 8'd0; iarg = 32'd0;
        do_finish = 1'b0; fkind = 4'd0; do_retry = 1'b0;
        rc = 16'd0; pc = 8'd0; np = 3'd0;

        n_phase = r_phase; n_stage = r_stage; n_wait = r_wait; n_retry = r_retry;
        n_poll = r_poll; n_cmd = r_cmd; n_pos = r_pos; n_arg = r_arg;
        n_rep0 = r_rep0; n_rep2 = r_rep2; n_kind = r_kind; n_pend = r_pend;
        n_notinit = r_notinit; n_pfx = r_pfx; n_fast = r_fast;
        tx_req = 1'b0; tx_cs = 1'b1; tx_byte = 8'hFF; rejected = 1'b0;

        if (!i_opcode) begin
            if (i_drive_number != 8'd0) begin
                rejected = 1'b1;
            end else begin
                n_fast = 1'b0; n_pfx = 1'b0;
                n_pos = 3'd0; n_poll = 8'd0; n_retry = 16'd0;
                if (r_wake_lim == 8'd0) begin
                    n_stage = ST_CMD0;
                    do_issue = 1'b1; icmd = CMD_GO_IDLE;
                end else begin
                    n_phase = PH_WAKE;
                    n_wait = {8'd0, r_wake_lim - 8'd1};
                    tx_req = 1'b1;
                end
            end
        end else begin
            unique case (r_phase)
                PH_WAKE: begin
                    if (r_wait != 16'd0) begin
                        n_wait = r_wait - 16'd1; tx_req = 1'b1;
                    end else begin
                        n_stage = ST_CMD0; do_issue = 1'b1; icmd = CMD_GO_IDLE;
                    end
                end
                PH_DESEL: begin
                    n_phase = PH_SEL; tx_req = 1'b1; tx_cs = 1'b0;
                end
                PH_SEL: begin
                    n_phase = PH_READY; n_wait = r_ready_lim;
                    tx_req = 1'b1; tx_cs = 1'b0;
                end
                PH_READY: begin
                    if (r == 8'hFF) begin
                        n_phase = PH_FRAME; n_pos = 3'd0;
                        tx_req = 1'b1; tx_cs = 1'b0;
                        tx_byte = frame_byte(3'd0, r_cmd, r_arg, r_pfx);
                    end else if (r_wait == 16'd0) begin
                        do_cmd = 1'b1; resp = 8'hFF;
                    end else begin
                        n_wait = r_wait - 16'd1; tx_req = 1'b1; tx_cs = 1'b0;
                    end
                end
                PH_FRAME: begin
                    tx_req = 1'b1; tx_cs = 1'b0;
                    if (r_pos < 3'd5) begin
                        n_pos = r_pos + 3'd1;
                        tx_byte = frame_byte(r_pos + 3'd1, r_cmd, r_arg, r_pfx);
                    end else begin
                        n_phase = PH_RESP; n_poll = r_poll_lim;
                    end
                end
                PH_RESP: begin
                    pc = r_poll - 8'd1;
                    if (r[7]) n_poll = pc;
                    if (r[7] && pc != 8'd0) begin
                        tx_req = 1'b1; tx_cs = 1'b0;
                    end else begin
                        do_cmd = 1'b1; resp = r;
                    end
                end
                PH_R7, PH_OCR: begin
                    np = r_pos + 3'd1;
                    if (r_pos[1:0] == 2'd0) n_rep0 = r;
                    if (r_pos[1:0] == 2'd2) n_rep2 = r;
                    n_pos = np;
                    if (np < 3'd4) begin
                        tx_req = 1'b1; tx_cs = 1'b0;
                    end else if (r_phase == PH_R7) begin
                        // byte 3 is the current one
                        if (r_rep2 == 8'h01 && ((r_pos[1:0] == 2'd3) ? r : 8'h00) == 8'hAA)
                        begin
                            n_stage = ST_V2_INIT; rc = r_retry_lim; do_retry = 1'b1;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end else if (r_rep0[6]) begin
                        do_finish = 1'b1; fkind = KIND_SD2 | KIND_BLOCK;
                    end else begin
                        n_stage = ST_V2_CMD16;
                        do_issue = 1'b1; icmd = CMD_BLKLEN; iarg = 32'd512;
                    end
                end
                PH_FINAL: begin
                    n_notinit = (r_kind == 4'd0);
                    n_fast = (r_kind != 4'd0);
                    n_phase = PH_DONE;
                end
                default: ;
            endcase
        end

        // command completion and flow step
        if (do_cmd) begin
            if (r_pfx && resp <= 8'h01) begin
                n_pfx = 1'b0;
                n_phase = PH_DESEL; tx_req = 1'b1;
            end else begin
                n_pfx = 1'b0;
                unique case (r_stage)
                    ST_CMD0: begin
                        if (resp == 8'h01) begin
                            n_stage = ST_CMD8; do_issue = 1'b1;
                            icmd = CMD_IF_COND; iarg = 32'h1AA;
                        end else do_finish = 1'b1;
                    end
                    ST_CMD8: begin
                        if (resp == 8'h01) begin
                            n_phase = PH_R7; n_pos = 3'd0; tx_req = 1'b1; tx_cs = 1'b0;
                        end else begin
                            n_stage = ST_V1_PROBE; do_issue = 1'b1; icmd = ACMD41;
                        end
                    end
                    ST_V2_INIT: begin
                        if (resp == 8'h00) begin
                            n_stage = ST_CMD58; do_issue = 1'b1; icmd = CMD_OCR;
                        end else begin
                            rc = r_retry; do_retry = 1'b1;
                        end
                    end
                    ST_CMD58: begin
                        if (resp == 8'h00) begin
                            n_phase = PH_OCR; n_pos = 3'd0; tx_req = 1'b1; tx_cs = 1'b0;
                        end else do_finish = 1'b1;
                    end
                    ST_V2_CMD16: begin
                        do_finish = 1'b1; fkind = (resp == 8'h00) ? KIND_SD2 : 4'd0;
                    end
                    ST_V1_PROBE: begin
                        n_pend = (resp <= 8'h01) ? KIND_SD1 : KIND_MMC;
                        n_stage = ST_V1_INIT; rc = r_retry_lim; do_retry = 1'b1;
                    end
                    ST_V1_INIT: begin
                        if (resp == 8'h00) begin
                            n_stage = ST_V1_CMD16; do_issue = 1'b1;
                            icmd = CMD_BLKLEN; iarg = 32'd512;
                        end else begin
                            rc = r_retry; do_retry = 1'b1;
                        end
                    end
                    default: begin
                        do_finish = 1'b1; fkind = (resp == 8'h00) ? r_pend : 4'd0;
                    end
                endcase
            end
        end

        if (do_retry) begin
            n_retry = rc - 16'd1;
            if (rc - 16'd1 == 16'd0) begin
                do_finish = 1'b1; fkind = 4'd0;
            end else begin
                do_issue = 1'b1;
                if (n_stage == ST_V2_INIT) begin
                    icmd = ACMD41; iarg = 32'h4000_0000;
                end else begin
                    icmd = (n_pend == KIND_SD1) ? ACMD41 : CMD_SEND_OP; iarg = 32'd0;
                end
            end
        end

        if (do_issue) begin
            n_cmd = icmd; n_arg = iarg; n_pfx = icmd[7];
            n_phase = PH_DESEL; tx_req = 1'b1; tx_cs = 1'b1; tx_byte = 8'hFF;
        end

        if (do_finish) begin
            n_kind = fkind; n_phase = PH_FINAL;
            tx_req = 1'b1; tx_cs = 1'b1; tx_byte = 8'hFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_lim <= 16'hFFFF; r_retry_lim <= 16'hFFFF;
            r_poll_lim <= 8'd10; r_wake_lim <= 8'd80;
            r_phase <= PH_IDLE; r_stage <= ST_CMD0;
            r_wait <= '0; r_retry <= '0; r_poll <= '0; r_cmd <= '0; r_pos <= '0;
            r_arg <= '0; r_rep0 <= '0; r_rep2 <= '0; r_kind <= '0; r_pend <= '0;
            r_notinit <= 1'b1; r_pfx <= 1'b0; r_fast <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_READY_WAIT: r_ready_lim <= pwdata[15:0];
                    REG_RETRY:      r_retry_lim <= pwdata[15:0];
                    REG_POLL:       r_poll_lim  <= pwdata[7:0];
                    default:        r_wake_lim  <= pwdata[7:0];
                endcase
            end
            if (accept) begin
                if (!rejected) begin
                    r_phase <= n_phase; r_stage <= n_stage; r_wait <= n_wait;
                    r_retry <= n_retry; r_poll <= n_poll; r_cmd <= n_cmd; r_pos <= n_pos;
                    r_arg <= n_arg; r_rep0 <= n_rep0; r_rep2 <= n_rep2; r_kind <= n_kind;
                    r_pend <= n_pend; r_notinit <= n_notinit; r_pfx <= n_pfx;
                    r_fast <= n_fast;
                end
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    logic done_c;
    assign done_c = rejected || (n_phase == PH_DONE && !tx_req);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_send_byte        <= tx_byte;
            o_exchange_request <= tx_req;
            o_chip_select_high <= tx_req ? tx_cs : 1'b1;
            o_fast_clock       <= rejected ? r_fast : n_fast;
            o_sequence_done    <= done_c;
            o_card_kind        <= (done_c && !rejected) ? n_kind : 4'd0;
            o_not_initialized  <= rejected ? 1'b1 : n_notinit;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_send_byte))
        else $error("result changed while stalled");
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_exchange_request |-> o_send_byte == 8'hFF && o_chip_select_high)
        else $error("idle result carries a byte");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sequence_done |-> o_card_kind == 4'd0)
        else $error("card kind shown before done");

endmodule
